### hdl/imaenc_pkg.sv
// shared types, constants and tables of the frame-based ima adpcm encoder
`timescale 1ns / 1ps
package imaenc_pkg;

  localparam int unsigned FRAME_SAMPLES = 320;
  localparam int unsigned POS_W = $clog2(FRAME_SAMPLES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_SAMPLES - 1);
  localparam logic [15:0] FRAME_LEN = 16'(FRAME_SAMPLES);

  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);
  localparam logic [CNT_W-1:0] HEADER_BYTES = CNT_W'(MAX_RESULTS);

  localparam int unsigned STEP_W = 15;
  localparam int unsigned IDX_W = 7;
  localparam logic signed [7:0] INDEX_MAX = 8'sd88;
  localparam logic signed [17:0] PRED_MAX = 18'sd32767;
  localparam logic signed [17:0] PRED_MIN = -18'sd32768;

  localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  localparam logic signed [7:0] INDEX_ADJUST [0:7] = '{
    -8'sd1, -8'sd1, -8'sd1, -8'sd1, 8'sd2, 8'sd4, 8'sd6, 8'sd8
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       run_last;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] cnt;
  } out_load_t;

endpackage

### hdl/imaenc_quant.sv
// ima adpcm quantizer: code, next predictor and next step index for one sample
`timescale 1ns / 1ps
module imaenc_quant
  import imaenc_pkg::*;
(
  input  logic signed [15:0]      sample,
  input  logic signed [15:0]      predictor,
  input  logic [IDX_W-1:0]        step_index,
  output logic [3:0]              code,
  output logic signed [15:0]      pred_nxt,
  output logic [IDX_W-1:0]        index_nxt
);

  logic signed [16:0] diff;
  logic               sign;
  logic [16:0]        d0;
  logic [16:0]        d1;
  logic [16:0]        d2;
  logic [16:0]        stp;
  logic [16:0]        vp;
  logic [2:0]         mag;
  logic signed [17:0] psum;
  logic signed [7:0]  nidx;

  always_comb begin
    diff = {sample[15], sample} - {predictor[15], predictor};
    sign = diff[16];
    d0   = sign ? 17'(-diff) : 17'(diff);
    stp  = {2'b00, STEP_TABLE[step_index]};
    vp   = stp >> 3;
    mag  = 3'd0;

    if (d0 >= stp) begin
      mag[2] = 1'b1;
      d1     = d0 - stp;
      vp     = vp + stp;
    end else begin
      d1 = d0;
    end
    if (d1 >= (stp >> 1)) begin
      mag[1] = 1'b1;
      d2     = d1 - (stp >> 1);
      vp     = vp + (stp >> 1);
    end else begin
      d2 = d1;
    end
    if (d2 >= (stp >> 2)) begin
      mag[0] = 1'b1;
      vp     = vp + (stp >> 2);
    end

    if (sign) begin
      psum = {{2{predictor[15]}}, predictor} - $signed({1'b0, vp});
    end else begin
      psum = {{2{predictor[15]}}, predictor} + $signed({1'b0, vp});
    end
    if (psum > PRED_MAX) begin
      pred_nxt = 16'sd32767;
    end else if (psum < PRED_MIN) begin
      pred_nxt = -16'sd32768;
    end else begin
      pred_nxt = psum[15:0];
    end

    nidx = $signed({1'b0, step_index}) + INDEX_ADJUST[mag];
    if (nidx < 8'sd0) begin
      index_nxt = '0;
    end else if (nidx > INDEX_MAX) begin
      index_nxt = IDX_W'(INDEX_MAX);
    end else begin
      index_nxt = nidx[IDX_W-1:0];
    end

    code = {sign, mag};
  end

endmodule

### hdl/imaenc_outbuf.sv
// result buffer: holds up to one sample's bytes and shifts them out one per transaction
`timescale 1ns / 1ps
module imaenc_outbuf
  import imaenc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  out_load_t load,
  input  out_item_t load_items [MAX_RESULTS],
  output logic      free,
  output logic      out_tvalid,
  input  logic      out_tready,
  output logic [7:0] out_tdata,  // data_byte
  output logic      out_tuser,   // run_last
  output logic      out_tlast    // frame_last
);

  out_item_t        items_r [MAX_RESULTS];
  logic [CNT_W-1:0] cnt_r;
  logic             take;

  assign take       = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = items_r[0].data_byte;
  assign out_tuser  = items_r[0].run_last;
  assign out_tlast  = items_r[0].frame_last;
  // empty now, or the last byte leaves this cycle
  assign free       = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load.en) begin
      cnt_r <= load.cnt;
    end else if (take) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load.en) begin
      items_r <= load_items;
    end else if (take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        items_r[i] <= items_r[i + 1];
      end
    end
  end

endmodule

### hdl/ima_adpcm_frame_encoder.sv
// frame-based ima adpcm encoder, top level
// a sample is coded from the input register; its bytes go to the output buffer when free
// throughput: one sample per cycle while codes flow; a frame's first sample emits six header
//   bytes and holds the input register until the output has taken five of them
// the predictor and step index update in a single combinational pass from the input register
// reset (synchronous, rst_n low): predictor, step index, held nibble and position clear,
//   so the next sample starts a frame; input and output buffers empty
`timescale 1ns / 1ps
module ima_adpcm_frame_encoder
  import imaenc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // data_byte
  output logic        out_tuser,  // run_last
  output logic        out_tlast   // frame_last
);

  logic               s1_v_r;
  logic signed [15:0] s1_sample_r;
  logic signed [15:0] pred_r;
  logic [IDX_W-1:0]   idx_r;
  logic [POS_W-1:0]   pos_r;
  logic [3:0]         held_r;

  logic               buf_free;
  logic               fire;
  logic               is_first;
  logic               is_last;
  logic [3:0]         code;
  logic signed [15:0] q_pred;
  logic [IDX_W-1:0]   q_idx;
  out_load_t          load;
  out_item_t          load_items [MAX_RESULTS];

  assign fire      = s1_v_r && buf_free;
  assign in_tready = !s1_v_r || fire;
  assign is_first  = (pos_r == '0);
  assign is_last   = (pos_r == LAST_POS);

  imaenc_quant u_quant (
    .sample     (s1_sample_r),
    .predictor  (pred_r),
    .step_index (idx_r),
    .code       (code),
    .pred_nxt   (q_pred),
    .index_nxt  (q_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_v_r <= 1'b1;
    end else if (fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_sample_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_r <= '0;
      idx_r  <= '0;
      pos_r  <= '0;
      held_r <= '0;
    end else if (fire) begin
      if (is_first) begin
        pred_r <= s1_sample_r;
        idx_r  <= '0;
        held_r <= '0;
      end else begin
        pred_r <= q_pred;
        idx_r  <= q_idx;
        // odd positions give the low nibble, even ones complete the byte
        held_r <= pos_r[0] ? code : 4'd0;
      end
      pos_r <= is_last ? '0 : pos_r + POS_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      load_items[i] = '0;
    end
    load.cnt = '0;
    if (is_first) begin
      load_items[0].data_byte  = s1_sample_r[7:0];
      load_items[1].data_byte  = s1_sample_r[15:8];
      load_items[3].data_byte  = FRAME_LEN[7:0];
      load_items[4].data_byte  = FRAME_LEN[15:8];
      load_items[5].run_last   = 1'b1;
      load_items[5].frame_last = is_last;
      load.cnt                 = HEADER_BYTES;
    end else if (pos_r[0]) begin
      // odd last code goes out with a zero high nibble
      load_items[0].data_byte  = {4'd0, code};
      load_items[0].run_last   = 1'b1;
      load_items[0].frame_last = 1'b1;
      load.cnt                 = is_last ? CNT_W'(1) : '0;
    end else begin
      load_items[0].data_byte  = {code, held_r};
      load_items[0].run_last   = 1'b1;
      load_items[0].frame_last = is_last;
      load.cnt                 = CNT_W'(1);
    end
    load.en = fire && (load.cnt != '0);
  end

  imaenc_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_items (load_items),
    .free       (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
